>>> rtl/rbpt_pkg.sv
// ----------------------------------------------------------------------------
// rbpt_pkg
// Shared types and constants of the red blob proximity tracker.
// ----------------------------------------------------------------------------
package rbpt_pkg;

	// fixed field widths
	localparam int SIZE_W   = 21;
	localparam int RADIUS_W = 10;
	localparam int COLOR_W  = 8;

	localparam logic [SIZE_W-1:0]   SIZE_MAX     = {SIZE_W{1'b1}};
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(50);
	localparam logic [COLOR_W-1:0]  RED_FULL     = COLOR_W'(255);

	// item kinds on the input channel
	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_EOF   = 1'b1
	} op_t;

	// control word that travels with a beat down the cell chain
	typedef struct packed {
		logic valid;
		logic eof;
		logic claimed;
	} ctl_t;

endpackage

>>> rtl/red_blob_proximity_tracker.sv
// ----------------------------------------------------------------------------
// red_blob_proximity_tracker
// Groups red pixels of a raster stream into proximity clusters and reports
// the largest cluster at each end of frame.
// ----------------------------------------------------------------------------
// The cluster table is a chain of MAX_CLUSTERS cells, one entry each. A
// pixel beat walks down the chain one cell per cycle while it is not
// stalled; the first cell whose last position lies within the radius
// takes it, otherwise the first empty cell opens a new cluster, and a
// pixel that leaves the chain unclaimed sets the overflow flag. One input
// beat is taken every cycle unless input is stalled; the result of an
// end-of-frame beat is loaded into the output register once the beat has
// passed every cell register of the chain. The end-of-frame beat collects
// the largest cluster and clears each cell as it passes, so no clearing
// pass is needed after reset or between frames. Input is stalled only
// while a report sits at the chain end and the output register is full
// and stalled. Write the radius only while the block is idle.
// ----------------------------------------------------------------------------
module red_blob_proximity_tracker #(
	parameter int MAX_CLUSTERS = 32,
	parameter int COORD_BITS   = 10,
	localparam int CNT_W       = $clog2(MAX_CLUSTERS + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [rbpt_pkg::RADIUS_W-1:0]  cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           op,
	input  logic [COORD_BITS-1:0]          row,
	input  logic [COORD_BITS-1:0]          col,
	input  logic [rbpt_pkg::COLOR_W-1:0]   blue,
	input  logic [rbpt_pkg::COLOR_W-1:0]   green,
	input  logic [rbpt_pkg::COLOR_W-1:0]   red,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           found,
	output logic [COORD_BITS-1:0]          start_row,
	output logic [COORD_BITS-1:0]          start_col,
	output logic [rbpt_pkg::SIZE_W-1:0]    pixel_count,
	output logic [CNT_W-1:0]               cluster_count,
	output logic                           overflow
);
	import rbpt_pkg::*;

	logic [RADIUS_W-1:0]   radius_q;
	logic                  adv;
	logic                  is_red;

	ctl_t                  ctl_c       [MAX_CLUSTERS+1];
	logic [COORD_BITS-1:0] row_c       [MAX_CLUSTERS+1];
	logic [COORD_BITS-1:0] col_c       [MAX_CLUSTERS+1];
	logic [COORD_BITS-1:0] best_row_c  [MAX_CLUSTERS+1];
	logic [COORD_BITS-1:0] best_col_c  [MAX_CLUSTERS+1];
	logic [SIZE_W-1:0]     best_size_c [MAX_CLUSTERS+1];
	logic [CNT_W-1:0]      best_cnt_c  [MAX_CLUSTERS+1];

	// proximity radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_wr_en) begin
			radius_q <= cfg_wr_data;
		end
	end

	// pixel marking and chain entry; non-red pixels never enter
	always_comb begin
		is_red            = (blue == '0) && (green == '0) && (red == RED_FULL);
		in_stall          = !adv;
		ctl_c[0].valid    = in_valid && adv && ((op == OP_EOF) || is_red);
		ctl_c[0].eof      = (op == OP_EOF);
		ctl_c[0].claimed  = 1'b0;
		row_c[0]          = row;
		col_c[0]          = col;
		best_row_c[0]     = '0;
		best_col_c[0]     = '0;
		best_size_c[0]    = '0;
		best_cnt_c[0]     = '0;
	end

	// cluster cell chain
	for (genvar k = 0; k < MAX_CLUSTERS; k++) begin : g_cell
		rbpt_cell #(
			.COORD_BITS (COORD_BITS),
			.CNT_W      (CNT_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.adv         (adv),
			.radius      (radius_q),
			.ctl_i       (ctl_c[k]),
			.row_i       (row_c[k]),
			.col_i       (col_c[k]),
			.best_row_i  (best_row_c[k]),
			.best_col_i  (best_col_c[k]),
			.best_size_i (best_size_c[k]),
			.best_cnt_i  (best_cnt_c[k]),
			.ctl_o       (ctl_c[k+1]),
			.row_o       (row_c[k+1]),
			.col_o       (col_c[k+1]),
			.best_row_o  (best_row_c[k+1]),
			.best_col_o  (best_col_c[k+1]),
			.best_size_o (best_size_c[k+1]),
			.best_cnt_o  (best_cnt_c[k+1])
		);
	end

	// overflow tracking and result register
	rbpt_tail #(
		.COORD_BITS (COORD_BITS),
		.CNT_W      (CNT_W)
	) u_tail (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl_i         (ctl_c[MAX_CLUSTERS]),
		.best_row_i    (best_row_c[MAX_CLUSTERS]),
		.best_col_i    (best_col_c[MAX_CLUSTERS]),
		.best_size_i   (best_size_c[MAX_CLUSTERS]),
		.best_cnt_i    (best_cnt_c[MAX_CLUSTERS]),
		.out_stall     (out_stall),
		.adv           (adv),
		.out_valid     (out_valid),
		.found         (found),
		.start_row     (start_row),
		.start_col     (start_col),
		.pixel_count   (pixel_count),
		.cluster_count (cluster_count),
		.overflow      (overflow)
	);

endmodule

>>> rtl/rbpt_cell.sv
// ----------------------------------------------------------------------------
// rbpt_cell
// One cluster slot of the tracker chain. Holds one cluster entry, matches
// or opens it for passing pixels, and folds itself into a passing
// end-of-frame beat before clearing.
// ----------------------------------------------------------------------------
module rbpt_cell #(
	parameter int COORD_BITS = 10,
	parameter int CNT_W      = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  logic [rbpt_pkg::RADIUS_W-1:0]  radius,
	input  rbpt_pkg::ctl_t                 ctl_i,
	input  logic [COORD_BITS-1:0]          row_i,
	input  logic [COORD_BITS-1:0]          col_i,
	input  logic [COORD_BITS-1:0]          best_row_i,
	input  logic [COORD_BITS-1:0]          best_col_i,
	input  logic [rbpt_pkg::SIZE_W-1:0]    best_size_i,
	input  logic [CNT_W-1:0]               best_cnt_i,
	output rbpt_pkg::ctl_t                 ctl_o,
	output logic [COORD_BITS-1:0]          row_o,
	output logic [COORD_BITS-1:0]          col_o,
	output logic [COORD_BITS-1:0]          best_row_o,
	output logic [COORD_BITS-1:0]          best_col_o,
	output logic [rbpt_pkg::SIZE_W-1:0]    best_size_o,
	output logic [CNT_W-1:0]               best_cnt_o
);
	import rbpt_pkg::*;

	localparam int CMP_W = (COORD_BITS > RADIUS_W) ? COORD_BITS : RADIUS_W;

	// entry storage
	logic                  valid_q;
	logic [COORD_BITS-1:0] start_row_q;
	logic [COORD_BITS-1:0] start_col_q;
	logic [COORD_BITS-1:0] last_row_q;
	logic [COORD_BITS-1:0] last_col_q;
	logic [SIZE_W-1:0]     size_q;

	// beat handed to the next cell
	ctl_t                  ctl_q;
	logic [COORD_BITS-1:0] row_q;
	logic [COORD_BITS-1:0] col_q;
	logic [COORD_BITS-1:0] best_row_q;
	logic [COORD_BITS-1:0] best_col_q;
	logic [SIZE_W-1:0]     best_size_q;
	logic [CNT_W-1:0]      best_cnt_q;

	logic [COORD_BITS-1:0] drow;
	logic [COORD_BITS-1:0] dcol;
	logic                  hit;
	logic                  is_pix;
	logic                  is_eof;
	logic                  join_here;
	logic                  open_here;
	logic                  take_best;

	// distance check against the last pixel of this cluster
	always_comb begin
		drow = (last_row_q >= row_i) ? (last_row_q - row_i) : (row_i - last_row_q);
		dcol = (last_col_q >= col_i) ? (last_col_q - col_i) : (col_i - last_col_q);
		hit  = valid_q
			&& (CMP_W'(drow) <= CMP_W'(radius))
			&& (CMP_W'(dcol) <= CMP_W'(radius));
	end

	always_comb begin
		is_pix    = adv && ctl_i.valid && !ctl_i.eof;
		is_eof    = adv && ctl_i.valid && ctl_i.eof;
		join_here = is_pix && !ctl_i.claimed && hit;
		open_here = is_pix && !ctl_i.claimed && !valid_q;
		take_best = valid_q && ((best_cnt_i == '0) || (size_q > best_size_i));
	end

	// entry valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (is_eof) begin
			valid_q <= 1'b0;
		end else if (open_here) begin
			valid_q <= 1'b1;
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		if (open_here) begin
			start_row_q <= row_i;
			start_col_q <= col_i;
			last_row_q  <= row_i;
			last_col_q  <= col_i;
			size_q      <= SIZE_W'(1);
		end else if (join_here) begin
			last_row_q <= row_i;
			last_col_q <= col_i;
			if (size_q != SIZE_MAX) begin
				size_q <= size_q + SIZE_W'(1);
			end
		end
	end

	// control of the outgoing beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q.valid   <= ctl_i.valid;
			ctl_q.eof     <= ctl_i.eof;
			ctl_q.claimed <= ctl_i.claimed || (!ctl_i.eof && (hit || !valid_q));
		end
	end

	// payload of the outgoing beat
	always_ff @(posedge clk) begin
		if (adv) begin
			row_q <= row_i;
			col_q <= col_i;
			if (ctl_i.eof && take_best) begin
				best_row_q  <= start_row_q;
				best_col_q  <= start_col_q;
				best_size_q <= size_q;
			end else begin
				best_row_q  <= best_row_i;
				best_col_q  <= best_col_i;
				best_size_q <= best_size_i;
			end
			best_cnt_q <= best_cnt_i + CNT_W'(valid_q);
		end
	end

	assign ctl_o       = ctl_q;
	assign row_o       = row_q;
	assign col_o       = col_q;
	assign best_row_o  = best_row_q;
	assign best_col_o  = best_col_q;
	assign best_size_o = best_size_q;
	assign best_cnt_o  = best_cnt_q;

endmodule

>>> rtl/rbpt_tail.sv
// ----------------------------------------------------------------------------
// rbpt_tail
// End of the cell chain: notes pixels that found no free slot and turns an
// end-of-frame beat into the registered result beat.
// ----------------------------------------------------------------------------
module rbpt_tail #(
	parameter int COORD_BITS = 10,
	parameter int CNT_W      = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rbpt_pkg::ctl_t               ctl_i,
	input  logic [COORD_BITS-1:0]        best_row_i,
	input  logic [COORD_BITS-1:0]        best_col_i,
	input  logic [rbpt_pkg::SIZE_W-1:0]  best_size_i,
	input  logic [CNT_W-1:0]             best_cnt_i,
	input  logic                         out_stall,
	output logic                         adv,
	output logic                         out_valid,
	output logic                         found,
	output logic [COORD_BITS-1:0]        start_row,
	output logic [COORD_BITS-1:0]        start_col,
	output logic [rbpt_pkg::SIZE_W-1:0]  pixel_count,
	output logic [CNT_W-1:0]             cluster_count,
	output logic                         overflow
);
	import rbpt_pkg::*;

	logic                  ovf_q;
	logic                  out_valid_q;
	logic                  found_q;
	logic [COORD_BITS-1:0] start_row_q;
	logic [COORD_BITS-1:0] start_col_q;
	logic [SIZE_W-1:0]     pixel_count_q;
	logic [CNT_W-1:0]      cluster_count_q;
	logic                  overflow_q;
	logic                  eof_here;
	logic                  load;
	logic                  lost_pix;

	// hold the chain while a report waits for a full output register
	always_comb begin
		eof_here = ctl_i.valid && ctl_i.eof;
		adv      = !(eof_here && out_valid_q && out_stall);
		load     = eof_here && adv;
		lost_pix = ctl_i.valid && !ctl_i.eof && !ctl_i.claimed;
	end

	// table overflow flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				ovf_q <= 1'b0;
			end else if (lost_pix) begin
				ovf_q <= 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result beat
	always_ff @(posedge clk) begin
		if (load) begin
			found_q         <= (best_cnt_i != '0);
			start_row_q     <= best_row_i;
			start_col_q     <= best_col_i;
			pixel_count_q   <= best_size_i;
			cluster_count_q <= best_cnt_i;
			overflow_q      <= ovf_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = found_q;
	assign start_row     = start_row_q;
	assign start_col     = start_col_q;
	assign pixel_count   = pixel_count_q;
	assign cluster_count = cluster_count_q;
	assign overflow      = overflow_q;

endmodule

>>> rtl/rbpt_checker.sv
// ----------------------------------------------------------------------------
// rbpt_checker
// Port-level checks of the tracker, bound onto the top level.
// ----------------------------------------------------------------------------
module rbpt_checker #(
	parameter int COORD_BITS = 10,
	parameter int CNT_W      = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_stall,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic                           found,
	input  logic [COORD_BITS-1:0]          start_row,
	input  logic [COORD_BITS-1:0]          start_col,
	input  logic [rbpt_pkg::SIZE_W-1:0]    pixel_count,
	input  logic [CNT_W-1:0]               cluster_count
);

	// a stalled result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// input stalls only behind a full, stalled output
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && out_stall) |-> !in_stall)
		else $error("input stalled without a waiting result");

	// an empty frame reports all zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> (start_row == '0) && (start_col == '0)
			&& (pixel_count == '0) && (cluster_count == '0))
		else $error("empty frame reported nonzero cluster");

	// a found cluster has pixels and the table is not empty
	a_found_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> (pixel_count != '0) && (cluster_count != '0))
		else $error("found cluster with zero count");

endmodule

bind red_blob_proximity_tracker rbpt_checker #(
	.COORD_BITS (COORD_BITS),
	.CNT_W      (CNT_W)
) u_rbpt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.found         (found),
	.start_row     (start_row),
	.start_col     (start_col),
	.pixel_count   (pixel_count),
	.cluster_count (cluster_count)
);
